// File: rtl/core/sorted_timer_queue_assert.svh
// ----------------------------------------------------------------------------
// Sorted timer queue assertion macros
// Implication and next-cycle implication checks, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMER_QUEUE_ASSERT_SVH
`define SORTED_TIMER_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

`define STQ_ASSERT_IMPL(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("sorted_timer_queue: implication check failed");

`define STQ_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("sorted_timer_queue: next-cycle check failed");

`else

`define STQ_ASSERT_IMPL(lbl, clk, rst, pre, post)

`define STQ_ASSERT_NEXT(lbl, clk, rst, pre, post)

`endif

`endif

// File: rtl/core/stq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted timer queue package
// Widths, operation and result codes, and the queue entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package stq_pkg;

   localparam int NUM_TIMERS_DEF = 16;
   localparam int ID_W           = 4;
   localparam int ID_SLOTS       = 2 ** ID_W;
   localparam int COUNT_W        = 32;
   localparam int STEP_W         = 16;
   localparam int KIND_W         = 3;
   localparam int RES_W          = 2;
   localparam int PEND_W         = 5;

   localparam logic [KIND_W-1:0] KIND_ADVANCE   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_START_REL = 3'd1;
   localparam logic [KIND_W-1:0] KIND_START_ABS = 3'd2;
   localparam logic [KIND_W-1:0] KIND_STOP      = 3'd3;

   localparam logic [RES_W-1:0] RES_FIRED = 2'd0;
   localparam logic [RES_W-1:0] RES_DONE  = 2'd1;
   localparam logic [RES_W-1:0] RES_FULL  = 2'd2;

   typedef struct packed {
      logic [ID_W-1:0]    owner;
      logic [COUNT_W-1:0] expiry;
   } entry_type;

endpackage

`default_nettype wire

// File: rtl/core/stq_alu.sv
// ----------------------------------------------------------------------------
// Sorted timer queue shared adder
// One 32-bit add/subtract unit; the sign of a difference gives wrap-aware order.
// ----------------------------------------------------------------------------
`default_nettype none

module stq_alu import stq_pkg::*; (
   input  logic [COUNT_W-1:0] op_a,
   input  logic [COUNT_W-1:0] op_b,
   input  logic               op_sub,
   output logic [COUNT_W-1:0] sum,
   output logic               neg
);

   assign sum = op_sub ? (op_a - op_b) : (op_a + op_b);
   assign neg = sum[COUNT_W-1];

endmodule

`default_nettype wire

// File: rtl/core/stq_store.sv
// ----------------------------------------------------------------------------
// Sorted timer queue entry store
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module stq_store import stq_pkg::*; #(
   parameter int DEPTH = NUM_TIMERS_DEF,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [AW-1:0]   wr_addr,
   input  entry_type       wr_data,
   input  logic [AW-1:0]   rd_addr,
   output entry_type       rd_data
);

   entry_type queue_mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         queue_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= queue_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/sorted_timer_queue.sv
// Flow: read, unknown kind or bad slot go straight to the result; advance scales
//   and adds, then takes each due timer off the head with a walk of the queue;
//   start/stop walk out an armed timer, then start walks in the new entry. One transaction in flight.
// The entry store is walked one entry a cycle.
// Reset (synchronous): counter zero, queue empty, ticks_per_step one.
// ----------------------------------------------------------------------------
// Sorted timer queue
// Tick counter with a wrap-aware sorted queue of one-shot timers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_timer_queue_assert.svh"

module sorted_timer_queue import stq_pkg::*; #(
   parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [KIND_W-1:0]  req_kind,
   input  logic [ID_W-1:0]    req_timer_id,
   input  logic [COUNT_W-1:0] req_elapsed_steps,
   input  logic [COUNT_W-1:0] req_offset_ticks,
   input  logic [COUNT_W-1:0] req_at_tick,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [RES_W-1:0]   rsp_result_kind,
   output logic [ID_W-1:0]    rsp_fired_timer,
   output logic [COUNT_W-1:0] rsp_count_value,
   output logic [PEND_W-1:0]  rsp_pending_count,
   output logic               rsp_last,
   input  logic               csr_wr_en,
   input  logic [STEP_W-1:0]  csr_wr_data
);

   localparam int AW    = $clog2(NUM_TIMERS);
   localparam int LEN_W = $clog2(NUM_TIMERS + 1);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(NUM_TIMERS);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_MUL   = 9'b000000010,
      S_ADD   = 9'b000000100,
      S_HEAD  = 9'b000001000,
      S_FIND  = 9'b000010000,
      S_DOWN  = 9'b000100000,
      S_INS   = 9'b001000000,
      S_SHIFT = 9'b010000000,
      S_EMIT  = 9'b100000000
   } state_type;

   state_type          state_ff, state_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [ID_W-1:0]    id_ff, id_in;
   logic [COUNT_W-1:0] opnd_ff, opnd_in;
   logic [COUNT_W-1:0] tick_ff, tick_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [ID_SLOTS-1:0] pending_ff, pending_in;
   logic [LEN_W-1:0]   idx_ff, idx_in;
   logic [ID_W-1:0]    rm_id_ff, rm_id_in;
   entry_type          carry_ff, carry_in;
   logic               have_fire_ff, have_fire_in;
   logic [RES_W-1:0]   res_kind_ff, res_kind_in;
   logic [ID_W-1:0]    res_id_ff, res_id_in;
   logic               res_last_ff, res_last_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [RES_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [PEND_W-1:0]  rsp_pend_ff, rsp_pend_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [STEP_W-1:0]  step_eff;
   logic [COUNT_W-1:0] product;
   logic [COUNT_W-1:0] alu_a, alu_b, alu_sum;
   logic               alu_sub, alu_neg;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   entry_type          mem_wdata;
   entry_type          rd_data;
   logic [LEN_W-1:0]   dn_idx;
   logic               at_end, full, due;

   assign step_eff = (step_ff == '0) ? STEP_W'(1) : step_ff;
   assign product  = opnd_ff * COUNT_W'(step_eff);
   assign dn_idx   = idx_ff - LEN_W'(1);
   assign at_end   = (idx_ff == len_ff);
   assign full     = (len_ff == LEN_MAX);
   assign due      = (len_ff != '0) && !alu_neg;

   stq_alu u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .op_sub (alu_sub),
      .sum    (alu_sum),
      .neg    (alu_neg)
   );

   stq_store #(.DEPTH(NUM_TIMERS)) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (idx_in[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      id_in        = id_ff;
      opnd_in      = opnd_ff;
      tick_in      = tick_ff;
      step_in      = csr_wr_en ? csr_wr_data : step_ff;
      len_in       = len_ff;
      pending_in   = pending_ff;
      idx_in       = idx_ff;
      rm_id_in     = rm_id_ff;
      carry_in     = carry_ff;
      have_fire_in = have_fire_ff;
      res_kind_in  = res_kind_ff;
      res_id_in    = res_id_ff;
      res_last_in  = res_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_count_in = rsp_count_ff;
      rsp_pend_in  = rsp_pend_ff;
      rsp_last_in  = rsp_last_ff;
      alu_a        = tick_ff;
      alu_b        = opnd_ff;
      alu_sub      = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff[AW-1:0];
      mem_wdata    = rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in      = req_kind;
               id_in        = req_timer_id;
               rm_id_in     = req_timer_id;
               have_fire_in = 1'b0;
               res_kind_in  = RES_DONE;
               res_id_in    = req_timer_id;
               res_last_in  = 1'b1;
               idx_in       = '0;
               priority if (req_kind == KIND_ADVANCE) begin
                  opnd_in  = req_elapsed_steps;
                  state_in = S_MUL;
               end else if (req_kind == KIND_START_REL || req_kind == KIND_START_ABS ||
                            req_kind == KIND_STOP) begin
                  opnd_in = (req_kind == KIND_START_REL) ? req_offset_ticks : req_at_tick;
                  priority if (int'(req_timer_id) >= NUM_TIMERS) begin
                     res_kind_in = RES_FULL;
                     state_in    = S_EMIT;
                  end else if (req_kind != KIND_STOP) begin
                     state_in = S_ADD;
                  end else if (pending_ff[req_timer_id]) begin
                     state_in = S_FIND;
                  end else begin
                     state_in = S_EMIT;
                  end
               end else begin
                  res_id_in = '0;
                  state_in  = S_EMIT;
               end
            end
         end

         S_MUL: begin
            opnd_in  = product;
            state_in = S_ADD;
         end

         S_ADD: begin
            alu_a  = (kind_ff == KIND_START_ABS) ? '0 : tick_ff;
            alu_b  = opnd_ff;
            idx_in = '0;
            if (kind_ff == KIND_ADVANCE) begin
               tick_in  = alu_sum;
               state_in = S_HEAD;
            end else begin
               opnd_in  = alu_sum;
               state_in = pending_ff[id_ff] ? S_FIND : S_INS;
            end
         end

         S_HEAD: begin
            alu_a   = tick_ff;
            alu_b   = rd_data.expiry;
            alu_sub = 1'b1;
            idx_in  = '0;
            if (have_fire_ff) begin
               res_kind_in = RES_FIRED;
               res_id_in   = rm_id_ff;
               res_last_in = !due;
               rm_id_in    = rd_data.owner;
               state_in    = S_EMIT;
            end else if (due) begin
               rm_id_in     = rd_data.owner;
               have_fire_in = 1'b1;
               state_in     = S_FIND;
            end else begin
               res_kind_in = RES_DONE;
               res_id_in   = '0;
               res_last_in = 1'b1;
               state_in    = S_EMIT;
            end
         end

         S_FIND, S_DOWN: begin
            if (at_end) begin
               pending_in[rm_id_ff] = 1'b0;
               if (state_ff == S_DOWN) begin
                  len_in = len_ff - LEN_W'(1);
               end
               idx_in = '0;
               priority if (kind_ff == KIND_ADVANCE) begin
                  state_in = S_HEAD;
               end else if (kind_ff == KIND_STOP) begin
                  state_in = S_EMIT;
               end else begin
                  state_in = S_INS;
               end
            end else begin
               idx_in = idx_ff + LEN_W'(1);
               if (state_ff == S_DOWN) begin
                  mem_we    = 1'b1;
                  mem_waddr = dn_idx[AW-1:0];
                  mem_wdata = rd_data;
               end else if (rd_data.owner == rm_id_ff) begin
                  state_in = S_DOWN;
               end
            end
         end

         S_INS: begin
            alu_a     = opnd_ff;
            alu_b     = rd_data.expiry;
            alu_sub   = 1'b1;
            mem_wdata = '{owner: id_ff, expiry: opnd_ff};
            priority if (full) begin
               state_in = S_EMIT;
            end else if (at_end) begin
               mem_we              = 1'b1;
               len_in              = len_ff + LEN_W'(1);
               pending_in[id_ff]   = 1'b1;
               state_in            = S_EMIT;
            end else if (alu_neg) begin
               mem_we   = 1'b1;
               carry_in = rd_data;
               idx_in   = idx_ff + LEN_W'(1);
               state_in = S_SHIFT;
            end else begin
               idx_in = idx_ff + LEN_W'(1);
            end
         end

         S_SHIFT: begin
            mem_we    = 1'b1;
            mem_wdata = carry_ff;
            if (at_end) begin
               len_in            = len_ff + LEN_W'(1);
               pending_in[id_ff] = 1'b1;
               state_in          = S_EMIT;
            end else begin
               carry_in = rd_data;
               idx_in   = idx_ff + LEN_W'(1);
            end
         end

         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = res_kind_ff;
               rsp_id_in    = res_id_ff;
               rsp_count_in = tick_ff;
               rsp_pend_in  = PEND_W'(len_ff);
               rsp_last_in  = res_last_ff;
               idx_in       = '0;
               state_in     = res_last_ff ? S_IDLE : S_FIND;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tick_ff      <= '0;
         step_ff      <= STEP_W'(1);
         len_ff       <= '0;
         pending_ff   <= '0;
         have_fire_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         step_ff      <= step_in;
         len_ff       <= len_in;
         pending_ff   <= pending_in;
         have_fire_ff <= have_fire_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      id_ff        <= id_in;
      opnd_ff      <= opnd_in;
      idx_ff       <= idx_in;
      rm_id_ff     <= rm_id_in;
      carry_ff     <= carry_in;
      res_kind_ff  <= res_kind_in;
      res_id_ff    <= res_id_in;
      res_last_ff  <= res_last_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_count_ff <= rsp_count_in;
      rsp_pend_ff  <= rsp_pend_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = rsp_kind_ff;
   assign rsp_fired_timer   = rsp_id_ff;
   assign rsp_count_value   = rsp_count_ff;
   assign rsp_pending_count = rsp_pend_ff;
   assign rsp_last          = rsp_last_ff;

   `STQ_ASSERT_IMPL(a_len_bound, clock, reset, 1'b1, len_ff <= LEN_MAX)
   `STQ_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `STQ_ASSERT_IMPL(a_pending_matches_len, clock, reset, state_ff == S_IDLE,
                    $countones(pending_ff) == int'(len_ff))

endmodule

`default_nettype wire

// File: tb/stq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer queue checker
// Watches the request, response and CSR ports, keeps its own copy of the
// counter and timer queue, predicts every response and compares in order.
// ----------------------------------------------------------------------------
module stq_checker import stq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [KIND_W-1:0]  req_kind,
   input  logic [ID_W-1:0]    req_timer_id,
   input  logic [COUNT_W-1:0] req_elapsed_steps,
   input  logic [COUNT_W-1:0] req_offset_ticks,
   input  logic [COUNT_W-1:0] req_at_tick,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [RES_W-1:0]   rsp_result_kind,
   input  logic [ID_W-1:0]    rsp_fired_timer,
   input  logic [COUNT_W-1:0] rsp_count_value,
   input  logic [PEND_W-1:0]  rsp_pending_count,
   input  logic               rsp_last,
   input  logic               csr_wr_en,
   input  logic [STEP_W-1:0]  csr_wr_data,
   output int                 fail_count,
   output int                 outstanding
);

   localparam int FIRE_LIMIT = 16;

   typedef struct packed {
      logic [RES_W-1:0]   kind;
      logic [ID_W-1:0]    id;
      logic [COUNT_W-1:0] count;
      logic [PEND_W-1:0]  pending;
      logic               last;
   } timer_rsp_type;

   timer_rsp_type      awaited_rsp[$];
   logic [STEP_W-1:0]  step_size;
   logic [COUNT_W-1:0] tick_count;
   logic [COUNT_W-1:0] expiry_q[NUM_TIMERS_DEF];
   logic [ID_W-1:0]    owner_q[NUM_TIMERS_DEF];
   int                 queue_len;
   logic [NUM_TIMERS_DEF-1:0] armed;
   int                 errors;

   function automatic logic expires_before(logic [COUNT_W-1:0] a, logic [COUNT_W-1:0] b);
      logic [COUNT_W-1:0] diff;
      diff = a - b;
      return diff[COUNT_W-1];
   endfunction

   function automatic void unlink_timer(logic [ID_W-1:0] id);
      int pos;
      pos = -1;
      for (int i = 0; i < queue_len; i++) begin
         if (pos < 0 && owner_q[i] == id) pos = i;
      end
      if (pos >= 0) begin
         for (int i = pos; i < queue_len - 1; i++) begin
            expiry_q[i] = expiry_q[i+1];
            owner_q[i]  = owner_q[i+1];
         end
         queue_len--;
      end
      armed[id] = 1'b0;
   endfunction

   function automatic void link_timer(logic [ID_W-1:0] id, logic [COUNT_W-1:0] expiry);
      int pos;
      pos = 0;
      if (queue_len < NUM_TIMERS_DEF) begin
         while (pos < queue_len && !expires_before(expiry, expiry_q[pos])) pos++;
         for (int i = queue_len; i > pos; i--) begin
            expiry_q[i] = expiry_q[i-1];
            owner_q[i]  = owner_q[i-1];
         end
         expiry_q[pos] = expiry;
         owner_q[pos]  = id;
         queue_len++;
         armed[id] = 1'b1;
      end
   endfunction

   function automatic void queue_rsp(logic [RES_W-1:0] kind, logic [ID_W-1:0] id, logic last);
      timer_rsp_type r;
      r.kind    = kind;
      r.id      = id;
      r.count   = tick_count;
      r.pending = PEND_W'(queue_len);
      r.last    = last;
      awaited_rsp.push_back(r);
   endfunction

   function automatic void apply_timer_op(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                                          logic [COUNT_W-1:0] elapsed,
                                          logic [COUNT_W-1:0] offset,
                                          logic [COUNT_W-1:0] at);
      logic [COUNT_W-1:0] step;
      logic [ID_W-1:0]    who;
      timer_rsp_type      tail;
      int                 fired;
      fired = 0;
      case (kind)
         KIND_ADVANCE: begin
            step = (step_size == '0) ? COUNT_W'(1) : COUNT_W'(step_size);
            tick_count = tick_count + step * elapsed;
            while (fired < FIRE_LIMIT && queue_len > 0 &&
                   !expires_before(tick_count, expiry_q[0])) begin
               who = owner_q[0];
               unlink_timer(who);
               queue_rsp(RES_FIRED, who, 1'b0);
               fired++;
            end
            if (fired == 0) begin
               queue_rsp(RES_DONE, '0, 1'b1);
            end else begin
               tail = awaited_rsp.pop_back();
               tail.last = 1'b1;
               awaited_rsp.push_back(tail);
            end
         end
         KIND_START_REL, KIND_START_ABS, KIND_STOP: begin
            if (armed[id]) unlink_timer(id);
            if (kind == KIND_START_REL) link_timer(id, tick_count + offset);
            else if (kind == KIND_START_ABS) link_timer(id, at);
            queue_rsp(RES_DONE, id, 1'b1);
         end
         default: queue_rsp(RES_DONE, '0, 1'b1);
      endcase
   endfunction

   always @(posedge clock) begin
      timer_rsp_type want;
      timer_rsp_type got;
      if (reset) begin
         awaited_rsp.delete();
         step_size  = STEP_W'(1);
         tick_count = '0;
         queue_len  = 0;
         armed      = '0;
         for (int i = 0; i < NUM_TIMERS_DEF; i++) begin
            expiry_q[i] = '0;
            owner_q[i]  = '0;
         end
         errors = 0;
         fail_count  <= 0;
         outstanding <= 0;
      end else begin
         if (csr_wr_en) step_size = csr_wr_data;
         if (req_valid && req_ready) begin
            apply_timer_op(req_kind, req_timer_id, req_elapsed_steps, req_offset_ticks,
                           req_at_tick);
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_result_kind, rsp_fired_timer, rsp_count_value, rsp_pending_count,
                    rsp_last};
            if (awaited_rsp.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display(
                     "%0t: unexpected response kind %0d id %0d cnt %h pend %0d last %b",
                     $realtime, got.kind, got.id, got.count, got.pending, got.last);
            end else begin
               want = awaited_rsp.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display(
                        "%0t: exp/act kind %0d/%0d id %0d/%0d cnt %h/%h pend %0d/%0d last %b/%b",
                        $realtime, want.kind, got.kind, want.id, got.id,
                        want.count, got.count, want.pending, got.pending,
                        want.last, got.last);
               end
            end
         end
         fail_count  <= errors;
         outstanding <= awaited_rsp.size();
      end
   end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer queue testbench
// Directed corner transactions then random timer traffic over several step
// sizes, with random idling on both channels; the checker scores responses.
// ----------------------------------------------------------------------------
module tb_top;
   import stq_pkg::*;

   localparam logic [KIND_W-1:0] KIND_READ = 3'd4;
   localparam int PHASE_ITEMS = 109;

   logic               clock             = 1'b0;
   logic               reset             = 1'b1;
   logic               req_valid         = 1'b0;
   logic               req_ready;
   logic [KIND_W-1:0]  req_kind          = KIND_READ;
   logic [ID_W-1:0]    req_timer_id      = '0;
   logic [COUNT_W-1:0] req_elapsed_steps = '0;
   logic [COUNT_W-1:0] req_offset_ticks  = '0;
   logic [COUNT_W-1:0] req_at_tick       = '0;
   logic               rsp_valid;
   logic               rsp_ready         = 1'b0;
   logic [RES_W-1:0]   rsp_result_kind;
   logic [ID_W-1:0]    rsp_fired_timer;
   logic [COUNT_W-1:0] rsp_count_value;
   logic [PEND_W-1:0]  rsp_pending_count;
   logic               rsp_last;
   logic               csr_wr_en         = 1'b0;
   logic [STEP_W-1:0]  csr_wr_data       = '0;

   int                 fail_count;
   int                 outstanding;
   bit                 calm = 1'b0;
   logic [STEP_W-1:0]  cur_step = STEP_W'(1);
   logic [COUNT_W-1:0] seen_count = '0;

   sorted_timer_queue u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_timer_id      (req_timer_id),
      .req_elapsed_steps (req_elapsed_steps),
      .req_offset_ticks  (req_offset_ticks),
      .req_at_tick       (req_at_tick),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_fired_timer   (rsp_fired_timer),
      .rsp_count_value   (rsp_count_value),
      .rsp_pending_count (rsp_pending_count),
      .rsp_last          (rsp_last),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   stq_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_timer_id      (req_timer_id),
      .req_elapsed_steps (req_elapsed_steps),
      .req_offset_ticks  (req_offset_ticks),
      .req_at_tick       (req_at_tick),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_fired_timer   (rsp_fired_timer),
      .rsp_count_value   (rsp_count_value),
      .rsp_pending_count (rsp_pending_count),
      .rsp_last          (rsp_last),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .fail_count        (fail_count),
      .outstanding       (outstanding)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 34);
      if (rsp_valid && rsp_ready) seen_count <= rsp_count_value;
   end

   task automatic send_op(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                          input logic [COUNT_W-1:0] elapsed,
                          input logic [COUNT_W-1:0] offset,
                          input logic [COUNT_W-1:0] at);
      while (!calm && $urandom_range(0, 99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_kind          <= kind;
      req_timer_id      <= id;
      req_elapsed_steps <= elapsed;
      req_offset_ticks  <= offset;
      req_at_tick       <= at;
      do @(posedge clock); while (!req_ready);
   endtask

   // hold off until every predicted response has been taken
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_step(input logic [STEP_W-1:0] value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      cur_step     = value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic random_op();
      logic [COUNT_W-1:0] unit;
      logic [COUNT_W-1:0] elapsed;
      logic [COUNT_W-1:0] offset;
      logic [COUNT_W-1:0] at;
      logic [KIND_W-1:0]  kind;
      int                 pick;
      unit    = (cur_step == '0) ? COUNT_W'(1) : COUNT_W'(cur_step);
      elapsed = $urandom;
      offset  = $urandom;
      at      = $urandom;
      pick    = $urandom_range(0, 99);
      if (pick < 38) begin
         kind = KIND_ADVANCE;
         pick = $urandom_range(0, 99);
         if (pick < 8) elapsed = '0;
         else if (pick < 92) elapsed = $urandom_range(1, 12);
      end else if (pick < 62) begin
         kind = KIND_START_REL;
         pick = $urandom_range(0, 99);
         if (pick < 8) offset = '0;
         else if (pick < 88) offset = unit * $urandom_range(1, 10) + $urandom_range(0, 3);
      end else if (pick < 80) begin
         kind = KIND_START_ABS;
         pick = $urandom_range(0, 99);
         if (pick < 15) at = seen_count - $urandom_range(0, 40);
         else if (pick < 85) at = seen_count + unit * $urandom_range(0, 12);
      end else if (pick < 92) begin
         kind = KIND_STOP;
      end else begin
         kind = KIND_W'($urandom_range(4, 7));
      end
      send_op(kind, ID_W'($urandom_range(0, 15)), elapsed, offset, at);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_op(KIND_READ, 4'd0, '0, '0, '0);
      for (int k = 5; k <= 7; k++) send_op(KIND_W'(k), 4'd9, '1, '1, '1);
      send_op(KIND_ADVANCE, 4'd0, '0, '0, '0);
      send_op(KIND_START_REL, 4'd0, '0, '0, '0);
      send_op(KIND_START_ABS, 4'd15, '0, '0, 32'hFFFF_FFFF);
      send_op(KIND_STOP, 4'd3, '0, '0, '0);
      send_op(KIND_START_REL, 4'd3, '0, 32'hFFFF_FFFF, '0);
      send_op(KIND_START_REL, 4'd3, '0, 32'd5, '0);
      send_op(KIND_ADVANCE, 4'd0, '0, '0, '0);
      send_op(KIND_STOP, 4'd3, '0, '0, '0);
      send_op(KIND_ADVANCE, 4'd0, 32'hFFFF_FFFF, '0, '0);
      send_op(KIND_START_ABS, 4'd7, '0, '0, '0);
      send_op(KIND_ADVANCE, 4'd0, 32'd1, '0, '0);
      set_step('0);
      send_op(KIND_ADVANCE, 4'd0, 32'd3, '0, '0);
      set_step(16'hFFFF);
      send_op(KIND_ADVANCE, 4'd0, 32'hFFFF_FFFF, '0, '0);
      // full table, then one advance that fires every timer
      for (int i = 0; i < NUM_TIMERS_DEF; i++) begin
         send_op(KIND_START_REL, ID_W'(i), '0, COUNT_W'(i * 3), '0);
      end
      send_op(KIND_ADVANCE, 4'd0, 32'd1, '0, '0);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       set_step(STEP_W'($urandom_range(2, 65534)));
            1:       set_step(16'hFFFF);
            2:       set_step('0);
            default: set_step(STEP_W'(1));
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            calm = (phase == 1 && i >= 15 && i < 100);
            if (i == 60) drain_results();
            random_op();
         end
         calm = 1'b0;
      end

      drain_results();
      repeat (40) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/stq_pkg.sv
rtl/core/stq_alu.sv
rtl/core/stq_store.sv
rtl/core/sorted_timer_queue.sv
tb/stq_checker.sv
tb/tb_top.sv
